// ===== hw/rtl/ssd_pkg.sv =====
package ssd_pkg;

	localparam int PAL_ENTRIES_DEF = 256;
	localparam int COLOR_W         = 16;
	localparam logic [9:0] COL_MAX = 10'd1023;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PIXEL  = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;

	localparam logic FUNC_STREAM = 1'b0;
	localparam logic FUNC_PAL    = 1'b1;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_SEGS   = 3'd1,
		PH_SKIP   = 3'd2,
		PH_RUNW   = 3'd3,
		PH_PIXEL  = 3'd4
	} phase_t;

	typedef struct packed {
		logic               func;
		logic [7:0]         data_byte;
		logic [7:0]         pal_index;
		logic [COLOR_W-1:0] pal_rgb;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         row;
		logic [9:0]         column;
		logic [COLOR_W-1:0] color;
		logic               out_of_bounds;
		logic               image_end;
		logic [7:0]         img_width;
		logic [7:0]         img_height;
		logic [7:0]         img_x;
		logic [7:0]         img_y;
	} rsp_item_t;

endpackage

// ===== hw/rtl/ssd_ram.sv =====
module ssd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/sprite_span_decoder_top.sv =====
// Span-coded sprite decoder. Takes one command beat per cycle: a palette
// write (func=1) or the next byte of the sprite stream (func=0). Stream bytes
// walk a small parser (header, segment count, skip, run width, indices); each
// index byte looks up the palette RAM at the edge that accepts it, and the
// result moves from the lookup stage to the output register whenever the
// output register is not stalled. The parser and the palette port both take
// a new beat every cycle, so the sustained rate is one beat per cycle;
// cmd_stall rises only while a result is held in the lookup stage behind a
// stalled output register.
module sprite_span_decoder_top import ssd_pkg::*; #(
	parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_item_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	localparam int AW = $clog2(PALETTE_ENTRIES);
	localparam logic [8:0] ENTRIES_9 = 9'(PALETTE_ENTRIES);

	function automatic logic [9:0] col_sat(input logic [9:0] c, input logic [7:0] n);
		logic [10:0] s;
		s = {1'b0, c} + {3'b000, n};
		col_sat = (s > {1'b0, COL_MAX}) ? COL_MAX : s[9:0];
	endfunction

	// parser state
	phase_t     phase_q, phase_n;
	logic [1:0] hcnt_q, hcnt_n;
	logic [7:0] width_q, width_n, height_q, height_n, xoff_q, xoff_n, yoff_q, yoff_n;
	logic [7:0] row_q, row_n, segs_q, segs_n, run_q, run_n;
	logic [9:0] col_q, col_n;

	// result produced by this beat, before palette lookup
	logic       r_valid, r_end, r_oob;
	logic [1:0] r_kind;
	logic [7:0] r_row;
	logic [9:0] r_col;

	logic       accept, stream_acc, pal_we, adv;
	logic [7:0] b, row_inc, segs_dec;
	logic       row_done;

	// lookup stage
	logic       valid_s1, inrange_s1, end_s1, oob_s1;
	logic [1:0] kind_s1;
	logic [7:0] row_s1, width_s1, height_s1, xoff_s1, yoff_s1;
	logic [9:0] col_s1;
	logic [COLOR_W-1:0] rdata;

	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	assign adv        = !rsp_valid_q || !rsp_stall;
	assign cmd_stall  = valid_s1 && !adv;
	assign accept     = cmd_valid && !cmd_stall;
	assign stream_acc = accept && (cmd.func == FUNC_STREAM);
	assign pal_we     = accept && (cmd.func == FUNC_PAL) && ({1'b0, cmd.pal_index} < ENTRIES_9);
	assign b          = cmd.data_byte;
	assign row_inc    = row_q + 8'd1;
	assign row_done   = row_inc >= height_q;
	assign segs_dec   = (segs_q != 8'd0) ? segs_q - 8'd1 : 8'd0;

	ssd_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_pal (
		.clk   (clk),
		.we    (pal_we),
		.waddr (cmd.pal_index[AW-1:0]),
		.wdata (cmd.pal_rgb),
		.re    (stream_acc),
		.raddr (b[AW-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		phase_n  = phase_q;
		hcnt_n   = hcnt_q;
		width_n  = width_q;
		height_n = height_q;
		xoff_n   = xoff_q;
		yoff_n   = yoff_q;
		row_n    = row_q;
		segs_n   = segs_q;
		run_n    = run_q;
		col_n    = col_q;
		r_valid  = 1'b0;
		r_kind   = KIND_HEADER;
		r_row    = 8'd0;
		r_col    = 10'd0;
		r_oob    = 1'b0;
		r_end    = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				hcnt_n = hcnt_q + 2'd1;
				case (hcnt_q)
					2'd0: xoff_n = b;
					2'd1: yoff_n = b;
					2'd2: width_n = b;
					default: begin
						height_n = b;
						hcnt_n   = 2'd0;
						row_n    = 8'd0;
						col_n    = 10'd0;
						segs_n   = 8'd0;
						run_n    = 8'd0;
						r_valid  = 1'b1;
						r_end    = (b == 8'd0);
						phase_n  = (b == 8'd0) ? PH_HEADER : PH_SEGS;
					end
				endcase
			end
			PH_SEGS: begin
				col_n  = 10'd0;
				segs_n = b;
				if (b == 8'd0) begin
					row_n = row_inc;
					if (row_done) begin
						phase_n = PH_HEADER;
						hcnt_n  = 2'd0;
						r_valid = 1'b1;
						r_kind  = KIND_END;
						r_row   = row_q;
						r_end   = 1'b1;
					end else begin
						phase_n = PH_SEGS;
					end
				end else begin
					phase_n = PH_SKIP;
				end
			end
			PH_SKIP: begin
				col_n   = col_sat(col_q, {1'b0, b[7:1]});
				phase_n = PH_RUNW;
			end
			PH_RUNW: begin
				run_n = b;
				if (b == 8'd0) begin
					segs_n = segs_dec;
					if (segs_dec == 8'd0) begin
						col_n = 10'd0;
						row_n = row_inc;
						if (row_done) begin
							phase_n = PH_HEADER;
							hcnt_n  = 2'd0;
							r_valid = 1'b1;
							r_kind  = KIND_END;
							r_row   = row_q;
							r_end   = 1'b1;
						end else begin
							phase_n = PH_SEGS;
						end
					end else begin
						phase_n = PH_SKIP;
					end
				end else begin
					phase_n = PH_PIXEL;
				end
			end
			PH_PIXEL: begin
				r_valid = 1'b1;
				r_kind  = KIND_PIXEL;
				r_row   = row_q;
				r_col   = col_q;
				r_oob   = col_q >= {2'b00, width_q};
				col_n   = col_sat(col_q, 8'd1);
				run_n   = run_q - 8'd1;
				if (run_q == 8'd1) begin
					segs_n = segs_dec;
					if (segs_dec == 8'd0) begin
						col_n = 10'd0;
						row_n = row_inc;
						if (row_done) begin
							phase_n = PH_HEADER;
							hcnt_n  = 2'd0;
							r_end   = 1'b1;
						end else begin
							phase_n = PH_SEGS;
						end
					end else begin
						phase_n = PH_SKIP;
					end
				end
			end
			default: begin
				phase_n = PH_HEADER;
				hcnt_n  = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			hcnt_q   <= 2'd0;
			width_q  <= 8'd0;
			height_q <= 8'd0;
			xoff_q   <= 8'd0;
			yoff_q   <= 8'd0;
			row_q    <= 8'd0;
			segs_q   <= 8'd0;
			run_q    <= 8'd0;
			col_q    <= 10'd0;
		end else if (stream_acc) begin
			phase_q  <= phase_n;
			hcnt_q   <= hcnt_n;
			width_q  <= width_n;
			height_q <= height_n;
			xoff_q   <= xoff_n;
			yoff_q   <= yoff_n;
			row_q    <= row_n;
			segs_q   <= segs_n;
			run_q    <= run_n;
			col_q    <= col_n;
		end
	end

	// lookup stage: holds while stalled, palette read data holds with it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream_acc && r_valid) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream_acc) begin
			kind_s1    <= r_kind;
			row_s1     <= r_row;
			col_s1     <= r_col;
			oob_s1     <= r_oob;
			end_s1     <= r_end;
			inrange_s1 <= {1'b0, b} < ENTRIES_9;
			width_s1   <= width_n;
			height_s1  <= height_n;
			xoff_s1    <= xoff_n;
			yoff_s1    <= yoff_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			rsp_q.kind          <= kind_s1;
			rsp_q.row           <= row_s1;
			rsp_q.column        <= col_s1;
			rsp_q.color         <= (kind_s1 == KIND_PIXEL && inrange_s1) ? rdata : '0;
			rsp_q.out_of_bounds <= oob_s1;
			rsp_q.image_end     <= end_s1;
			rsp_q.img_width     <= width_s1;
			rsp_q.img_height    <= height_s1;
			rsp_q.img_x         <= xoff_s1;
			rsp_q.img_y         <= yoff_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== hw/rtl/ssd_chk.sv =====
module ssd_chk import ssd_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_item_t rsp
);

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result beat changed under stall");

	a_non_pixel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind != KIND_PIXEL |->
			rsp.column == 10'd0 && rsp.color == '0 && !rsp.out_of_bounds)
		else $error("non-pixel result carries pixel data");

	a_header_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_HEADER |-> rsp.image_end == (rsp.img_height == 8'd0))
		else $error("header end flag disagrees with height");

	a_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_END |-> rsp.image_end && rsp.img_height != 8'd0)
		else $error("empty end result without image end");

	a_oob: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_PIXEL |->
			rsp.out_of_bounds == (rsp.column >= {2'b00, rsp.img_width}))
		else $error("out of bounds flag wrong");

endmodule

bind sprite_span_decoder_top ssd_chk u_ssd_chk (.*);
